// ===== sv/tbi_pkg.sv =====
`timescale 1ns / 1ps

package tbi_pkg;

   localparam int MAX_POINTS  = 16;
   localparam int ANGLE_BITS  = 16;
   localparam int IDX_BITS    = $clog2(MAX_POINTS);
   localparam int CNT_BITS    = 5;
   localparam int PROD_BITS   = 2 * ANGLE_BITS;
   localparam int STEP_BITS   = $clog2(ANGLE_BITS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [IDX_BITS-1:0]     index;
      logic [ANGLE_BITS-1:0]   pan;
      logic [ANGLE_BITS-1:0]   lower;
      logic [ANGLE_BITS-1:0]   upper;
      logic [CNT_BITS-1:0]     count;
   } cmd_type;

   // front -> queue
   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   // queue -> back
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_PREV,
      BK_MUL_UP,
      BK_MUL_LO,
      BK_DIV_GO,
      BK_DIV_WAIT
   } back_state_type;

endpackage

// ===== sv/tbi_front.sv =====
`timescale 1ns / 1ps

module tbi_front
   import tbi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  queue_full,
   output logic                  busy,
   input  logic                  req_type,
   input  logic [IDX_BITS-1:0]   req_entry_index,
   input  logic [ANGLE_BITS-1:0] req_point_pan,
   input  logic [ANGLE_BITS-1:0] req_point_lower,
   input  logic [ANGLE_BITS-1:0] req_point_upper,
   input  logic [ANGLE_BITS-1:0] req_query_pan,
   input  logic                  csr_write_enable,
   input  logic [CNT_BITS-1:0]   csr_write_data,
   output push_type              push
);

   logic [CNT_BITS-1:0] points_ff;
   logic [CNT_BITS-1:0] points_in;
   logic [CNT_BITS-1:0] count_sat;

   assign points_in = csr_write_enable ? csr_write_data : points_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= '0;
      end else begin
         points_ff <= points_in;
      end
   end

   // clamp the search length to the table depth
   assign count_sat = (points_ff > CNT_BITS'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS) : points_ff;

   assign busy = queue_full;

   always_comb begin
      push.push      = start && !queue_full;
      push.cmd.op    = op_type'(req_type);
      push.cmd.index = req_entry_index;
      push.cmd.lower = req_point_lower;
      push.cmd.upper = req_point_upper;
      push.cmd.count = count_sat;
      unique case (op_type'(req_type))
         OP_LOAD:  push.cmd.pan = req_point_pan;
         OP_QUERY: push.cmd.pan = req_query_pan;
         default:  push.cmd.pan = req_query_pan;
      endcase
   end

endmodule

// ===== sv/tbi_cmd_queue.sv =====
`timescale 1ns / 1ps

module tbi_cmd_queue
   import tbi_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     full,
   output head_type head
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   fill_ff, fill_in;
   logic                   do_push;
   logic                   do_pop;

   assign full      = (fill_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign do_push   = push.push && !full;
   assign do_pop    = pop && (fill_ff != '0);
   assign head.valid = (fill_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ===== sv/tbi_divider.sv =====
`timescale 1ns / 1ps

module tbi_divider
   import tbi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [PROD_BITS-1:0]  dividend,
   input  logic [ANGLE_BITS-1:0] divisor,
   output logic                  done,
   output logic [ANGLE_BITS-1:0] quotient
);

   // restoring, one quotient bit per cycle; caller guarantees the upper
   // half of the dividend is below the divisor
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  cnt_ff, cnt_in;
   logic [ANGLE_BITS-1:0] rem_ff, rem_in;
   logic [ANGLE_BITS-1:0] sh_ff, sh_in;
   logic [ANGLE_BITS-1:0] div_ff, div_in;
   logic [ANGLE_BITS:0]   trial;
   logic [ANGLE_BITS:0]   diff;
   logic                  take;

   assign trial = {rem_ff, sh_ff[ANGLE_BITS-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign take  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_BITS'(ANGLE_BITS);
         rem_in  = dividend[PROD_BITS-1:ANGLE_BITS];
         sh_in   = dividend[ANGLE_BITS-1:0];
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = take ? diff[ANGLE_BITS-1:0] : trial[ANGLE_BITS-1:0];
         sh_in  = {sh_ff[ANGLE_BITS-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = sh_ff;

endmodule

// ===== sv/tbi_back.sv =====
`timescale 1ns / 1ps

module tbi_back
   import tbi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  head_type              head,
   output logic                  pop,
   output logic                  rsp_strobe,
   output logic                  rsp_reachable,
   output logic [ANGLE_BITS-1:0] rsp_tilt_upper,
   output logic [ANGLE_BITS-1:0] rsp_tilt_lower
);

   // breakpoint table, one write and one registered read port
   logic signed [ANGLE_BITS-1:0] pan_mem_ff   [MAX_POINTS];
   logic signed [ANGLE_BITS-1:0] lower_mem_ff [MAX_POINTS];
   logic signed [ANGLE_BITS-1:0] upper_mem_ff [MAX_POINTS];
   logic signed [ANGLE_BITS-1:0] rd_pan_ff, rd_lower_ff, rd_upper_ff;
   logic [IDX_BITS-1:0]          rd_addr;
   logic                         mem_we;

   back_state_type state_ff, state_in;

   logic [IDX_BITS-1:0]          idx_ff;
   logic [CNT_BITS-1:0]          count_ff;
   logic signed [ANGLE_BITS-1:0] pan_ff;
   logic signed [ANGLE_BITS-1:0] xe_ff, le_ff, ue_ff;
   logic signed [ANGLE_BITS-1:0] base_up_ff, base_lo_ff;
   logic [ANGLE_BITS-1:0]        mag_up_ff, mag_lo_ff;
   logic                         neg_up_ff, neg_lo_ff;
   logic [ANGLE_BITS-1:0]        den_ff, t_ff;
   logic [PROD_BITS-1:0]         prod_up_ff, prod_lo_ff;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic                  rsp_reach_ff, rsp_reach_in;
   logic [ANGLE_BITS-1:0] rsp_upper_ff, rsp_upper_in;
   logic [ANGLE_BITS-1:0] rsp_lower_ff, rsp_lower_in;

   logic                  is_query;
   logic                  hit;
   logic                  exact;
   logic                  last;
   logic                  div_start;
   logic                  done_up, done_lo;
   logic [ANGLE_BITS-1:0] q_up, q_lo;

   logic signed [ANGLE_BITS:0]   den_w, t_w, d_up_w, d_lo_w;
   logic signed [ANGLE_BITS+1:0] res_up_w, res_lo_w;

   assign is_query = head.valid && (head.cmd.op == OP_QUERY);
   assign hit      = (rd_pan_ff >= pan_ff);
   assign exact    = (rd_pan_ff == pan_ff);
   assign last     = (({1'b0, idx_ff} + 1'b1) == count_ff);

   // previous breakpoint arrives in BK_PREV
   assign den_w  = {xe_ff[ANGLE_BITS-1], xe_ff} - {rd_pan_ff[ANGLE_BITS-1], rd_pan_ff};
   assign t_w    = {pan_ff[ANGLE_BITS-1], pan_ff} - {rd_pan_ff[ANGLE_BITS-1], rd_pan_ff};
   assign d_up_w = {ue_ff[ANGLE_BITS-1], ue_ff} - {rd_upper_ff[ANGLE_BITS-1], rd_upper_ff};
   assign d_lo_w = {le_ff[ANGLE_BITS-1], le_ff} - {rd_lower_ff[ANGLE_BITS-1], rd_lower_ff};

   assign res_up_w = neg_up_ff
      ? {{2{base_up_ff[ANGLE_BITS-1]}}, base_up_ff} - {2'b00, q_up}
      : {{2{base_up_ff[ANGLE_BITS-1]}}, base_up_ff} + {2'b00, q_up};
   assign res_lo_w = neg_lo_ff
      ? {{2{base_lo_ff[ANGLE_BITS-1]}}, base_lo_ff} - {2'b00, q_lo}
      : {{2{base_lo_ff[ANGLE_BITS-1]}}, base_lo_ff} + {2'b00, q_lo};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (is_query && (head.cmd.count != '0)) begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            priority if (hit) begin
               state_in = (exact || (idx_ff == '0)) ? BK_IDLE : BK_PREV;
            end else if (last) begin
               state_in = BK_IDLE;
            end
         end
         BK_PREV:     state_in = BK_MUL_UP;
         BK_MUL_UP:   state_in = BK_MUL_LO;
         BK_MUL_LO:   state_in = BK_DIV_GO;
         BK_DIV_GO:   state_in = BK_DIV_WAIT;
         BK_DIV_WAIT: begin
            if (done_up && done_lo) begin
               state_in = BK_IDLE;
            end
         end
         default:     state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop           = 1'b0;
      mem_we        = 1'b0;
      rd_addr       = '0;
      div_start     = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_reach_in  = 1'b0;
      rsp_upper_in  = '0;
      rsp_lower_in  = '0;
      unique case (state_ff)
         BK_IDLE: begin
            pop = head.valid;
            if (head.valid && (head.cmd.op == OP_LOAD)) begin
               mem_we = 1'b1;
            end
            if (is_query && (head.cmd.count == '0)) begin
               rsp_strobe_in = 1'b1;
            end
         end
         BK_SCAN: begin
            rd_addr = hit ? idx_ff - 1'b1 : idx_ff + 1'b1;
            priority if (hit && exact) begin
               rsp_strobe_in = 1'b1;
               rsp_reach_in  = 1'b1;
               rsp_upper_in  = rd_upper_ff;
               rsp_lower_in  = rd_lower_ff;
            end else if (hit && (idx_ff == '0)) begin
               rsp_strobe_in = 1'b1;
            end else if (!hit && last) begin
               rsp_strobe_in = 1'b1;
            end
         end
         BK_DIV_GO: div_start = 1'b1;
         BK_DIV_WAIT: begin
            if (done_up && done_lo) begin
               rsp_strobe_in = 1'b1;
               rsp_reach_in  = 1'b1;
               rsp_upper_in  = res_up_w[ANGLE_BITS-1:0];
               rsp_lower_in  = res_lo_w[ANGLE_BITS-1:0];
            end
         end
         BK_PREV, BK_MUL_UP, BK_MUL_LO: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_reach_ff <= rsp_reach_in;
      rsp_upper_ff <= rsp_upper_in;
      rsp_lower_ff <= rsp_lower_in;
   end

   // table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pan_mem_ff[head.cmd.index]   <= head.cmd.pan;
         lower_mem_ff[head.cmd.index] <= head.cmd.lower;
         upper_mem_ff[head.cmd.index] <= head.cmd.upper;
      end
      rd_pan_ff   <= pan_mem_ff[rd_addr];
      rd_lower_ff <= lower_mem_ff[rd_addr];
      rd_upper_ff <= upper_mem_ff[rd_addr];
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            idx_ff   <= '0;
            count_ff <= head.cmd.count;
            pan_ff   <= head.cmd.pan;
         end
         BK_SCAN: begin
            idx_ff <= idx_ff + 1'b1;
            xe_ff  <= rd_pan_ff;
            le_ff  <= rd_lower_ff;
            ue_ff  <= rd_upper_ff;
         end
         BK_PREV: begin
            den_ff     <= den_w[ANGLE_BITS-1:0];
            t_ff       <= t_w[ANGLE_BITS-1:0];
            base_up_ff <= rd_upper_ff;
            base_lo_ff <= rd_lower_ff;
            neg_up_ff  <= d_up_w[ANGLE_BITS];
            neg_lo_ff  <= d_lo_w[ANGLE_BITS];
            mag_up_ff  <= d_up_w[ANGLE_BITS] ? ANGLE_BITS'(-d_up_w) : d_up_w[ANGLE_BITS-1:0];
            mag_lo_ff  <= d_lo_w[ANGLE_BITS] ? ANGLE_BITS'(-d_lo_w) : d_lo_w[ANGLE_BITS-1:0];
         end
         BK_MUL_UP: prod_up_ff <= mag_up_ff * t_ff;
         BK_MUL_LO: prod_lo_ff <= mag_lo_ff * t_ff;
         BK_DIV_GO, BK_DIV_WAIT: begin
         end
         default: begin
         end
      endcase
   end

   tbi_divider u_div_up (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_up_ff),
      .divisor  (den_ff),
      .done     (done_up),
      .quotient (q_up)
   );

   tbi_divider u_div_lo (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_lo_ff),
      .divisor  (den_ff),
      .done     (done_lo),
      .quotient (q_lo)
   );

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_reachable  = rsp_reach_ff;
   assign rsp_tilt_upper = rsp_upper_ff;
   assign rsp_tilt_lower = rsp_lower_ff;

endmodule

// ===== sv/tilt_bound_interpolator.sv =====
`timescale 1ns / 1ps
// Tilt limit lookup by pan angle over a table of up to 16 breakpoints.
// Input channel: a beat is taken on a rising edge with start high and busy low.
//   req_type selects load (writes slot req_entry_index) or query (req_query_pan).
//   Loads give no result; each query gives exactly one result beat.
// Result channel: rsp_strobe marks a beat that is valid for one cycle only;
//   there is no backpressure, the receiver must take every beat as it comes.
// Config: csr_write_enable/csr_write_data set points_in_use; write it idle only.
// Structure: the front takes beats into a 2-entry command queue; busy means
//   the queue is full. The back pops commands and runs them one at a time.
// The back scans linearly for the first breakpoint at or above the pan,
//   one entry a cycle through the registered table read. An empty table
//   is answered without a scan; an exact hit, a pan below the table or a
//   pan beyond the searched entries ends the scan; any other query is
//   interpolated with a multiply and the 16-step restoring divider.
//   A load writes its slot when the back pops it from the queue. Commands
//   queued behind a busy back wait for it to finish.
// Reset clears the queue, the sequencer and points_in_use to 0; the table
//   holds whatever it held and must be loaded before it is searched.
module tilt_bound_interpolator
   import tbi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_type,
   input  logic [IDX_BITS-1:0]   req_entry_index,
   input  logic [ANGLE_BITS-1:0] req_point_pan,
   input  logic [ANGLE_BITS-1:0] req_point_lower,
   input  logic [ANGLE_BITS-1:0] req_point_upper,
   input  logic [ANGLE_BITS-1:0] req_query_pan,
   output logic                  rsp_strobe,
   output logic                  rsp_reachable,
   output logic [ANGLE_BITS-1:0] rsp_tilt_upper,
   output logic [ANGLE_BITS-1:0] rsp_tilt_lower,
   input  logic                  csr_write_enable,
   input  logic [CNT_BITS-1:0]   csr_write_data
);

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   // front: takes beats, holds points_in_use, tags queries with the clamped count
   tbi_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .queue_full       (queue_full),
      .busy             (busy),
      .req_type         (req_type),
      .req_entry_index  (req_entry_index),
      .req_point_pan    (req_point_pan),
      .req_point_lower  (req_point_lower),
      .req_point_upper  (req_point_upper),
      .req_query_pan    (req_query_pan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push)
   );

   // keeps loads and queries in arrival order
   tbi_cmd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // back: table, scan sequencer, multiply and divide
   tbi_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_reachable  (rsp_reachable),
      .rsp_tilt_upper (rsp_tilt_upper),
      .rsp_tilt_lower (rsp_tilt_lower)
   );

endmodule

// ===== tb/tb_tilt_bound_interpolator.sv =====
`timescale 1ns / 1ps

module tb_tilt_bound_interpolator;
   import tbi_pkg::*;

   // Cycles with no beat and no result before the block counts as idle.
   // Covers the longest interpolated query plus loads still retiring.
   localparam int SETTLE_CYCLES = 48;
   // Quiet time after the last result before the verdict.
   localparam int TAIL_CYCLES   = 64;
   // Random beats to generate; the last stretch of them runs with no gaps.
   localparam int RANDOM_BEATS  = 1050;
   localparam int CALM_FROM     = 930;

   typedef enum logic [1:0] {
      ACT_BEAT,     // one beat on the request channel
      ACT_CSR,      // points_in_use write, issued only once the block is idle
      ACT_SETTLE    // hold off until every pending result has come back
   } action_kind;

   typedef struct {
      action_kind            kind;
      op_type                op;
      logic [IDX_BITS-1:0]   index;
      logic [ANGLE_BITS-1:0] pan;
      logic [ANGLE_BITS-1:0] lower;
      logic [ANGLE_BITS-1:0] upper;
      logic [ANGLE_BITS-1:0] qpan;
      logic [CNT_BITS-1:0]   count;
      bit                    calm;
   } stim_item;

   typedef struct packed {
      logic                  reachable;
      logic [ANGLE_BITS-1:0] upper;
      logic [ANGLE_BITS-1:0] lower;
   } tilt_result;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  start            = 1'b0;
   logic                  busy;
   logic                  req_type         = OP_LOAD;
   logic [IDX_BITS-1:0]   req_entry_index  = '0;
   logic [ANGLE_BITS-1:0] req_point_pan    = '0;
   logic [ANGLE_BITS-1:0] req_point_lower  = '0;
   logic [ANGLE_BITS-1:0] req_point_upper  = '0;
   logic [ANGLE_BITS-1:0] req_query_pan    = '0;
   logic                  rsp_strobe;
   logic                  rsp_reachable;
   logic [ANGLE_BITS-1:0] rsp_tilt_upper;
   logic [ANGLE_BITS-1:0] rsp_tilt_lower;
   logic                  csr_write_enable = 1'b0;
   logic [CNT_BITS-1:0]   csr_write_data   = '0;

   // Stimulus waiting for the driver, and results still owed by the block.
   stim_item   pending_actions [$];
   tilt_result expected_limits [$];

   // Shadow of the breakpoint table and of points_in_use, kept by the monitor.
   logic signed [ANGLE_BITS-1:0] tbl_pan   [MAX_POINTS];
   logic signed [ANGLE_BITS-1:0] tbl_lower [MAX_POINTS];
   logic signed [ANGLE_BITS-1:0] tbl_upper [MAX_POINTS];
   logic [CNT_BITS-1:0]          active_points = '0;

   int  error_count  = 0;
   int  random_beats = 0;
   int  idle_left    = 0;
   int  quiet_cycles = 0;
   bit  beat_calm    = 1'b0;

   tilt_bound_interpolator u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_entry_index  (req_entry_index),
      .req_point_pan    (req_point_pan),
      .req_point_lower  (req_point_lower),
      .req_point_upper  (req_point_upper),
      .req_query_pan    (req_query_pan),
      .rsp_strobe       (rsp_strobe),
      .rsp_reachable    (rsp_reachable),
      .rsp_tilt_upper   (rsp_tilt_upper),
      .rsp_tilt_lower   (rsp_tilt_lower),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // One limit between two breakpoints: s + trunc((e - s) * t / den).
   // Magnitudes stay below 2^32, so plain 64-bit math is exact here and
   // dividing the magnitude truncates toward zero.
   function automatic logic [ANGLE_BITS-1:0] lerp_limit(
      logic signed [ANGLE_BITS-1:0] s, logic signed [ANGLE_BITS-1:0] e,
      longint t, longint den);
      longint d;
      longint step;
      d    = longint'(e) - longint'(s);
      step = ((d < 0) ? -d : d) * t / den;
      return (d < 0) ? ANGLE_BITS'(longint'(s) - step)
                     : ANGLE_BITS'(longint'(s) + step);
   endfunction

   // Expected answer of a query against the shadow table.
   function automatic tilt_result predict_tilt(logic signed [ANGLE_BITS-1:0] pan);
      tilt_result r;
      int         n;
      int         hit;
      longint     xs;
      longint     xe;
      r   = '0;
      n   = (int'(active_points) > MAX_POINTS) ? MAX_POINTS : int'(active_points);
      hit = n;
      // first entry at or above the pan; walk down so the lowest index wins
      for (int i = n - 1; i >= 0; i--)
         if (tbl_pan[i] >= pan) hit = i;
      if (hit < n) begin
         if (tbl_pan[hit] == pan) begin
            r.reachable = 1'b1;
            r.upper     = tbl_upper[hit];
            r.lower     = tbl_lower[hit];
         end else if (hit != 0) begin
            // previous entry lies below the pan, so the span is positive
            xs          = longint'(tbl_pan[hit-1]);
            xe          = longint'(tbl_pan[hit]);
            r.reachable = 1'b1;
            r.upper     = lerp_limit(tbl_upper[hit-1], tbl_upper[hit],
                                     longint'(pan) - xs, xe - xs);
            r.lower     = lerp_limit(tbl_lower[hit-1], tbl_lower[hit],
                                     longint'(pan) - xs, xe - xs);
         end
      end
      return r;
   endfunction

   task automatic push_load(int idx, int pan, int lower, int upper);
      stim_item it;
      it.kind  = ACT_BEAT;
      it.op    = OP_LOAD;
      it.index = IDX_BITS'(idx);
      it.pan   = ANGLE_BITS'(pan);
      it.lower = ANGLE_BITS'(lower);
      it.upper = ANGLE_BITS'(upper);
      it.qpan  = ANGLE_BITS'($urandom);   // don't-care field, toggled anyway
      it.count = '0;
      it.calm  = (random_beats >= CALM_FROM);
      pending_actions.push_back(it);
      random_beats++;
   endtask

   task automatic push_query(int pan);
      stim_item it;
      it.kind  = ACT_BEAT;
      it.op    = OP_QUERY;
      it.index = IDX_BITS'($urandom);
      it.pan   = ANGLE_BITS'($urandom);
      it.lower = ANGLE_BITS'($urandom);
      it.upper = ANGLE_BITS'($urandom);
      it.qpan  = ANGLE_BITS'(pan);
      it.count = '0;
      it.calm  = (random_beats >= CALM_FROM);
      pending_actions.push_back(it);
      random_beats++;
   endtask

   task automatic push_control(action_kind kind, int count);
      stim_item it;
      it.kind  = kind;
      it.op    = OP_LOAD;
      it.index = '0;
      it.pan   = '0;
      it.lower = '0;
      it.upper = '0;
      it.qpan  = '0;
      it.count = CNT_BITS'(count);
      it.calm  = 1'b0;
      pending_actions.push_back(it);
   endtask

   // Tilt limit: mostly random, with the rails now and then.
   function automatic int pick_limit();
      case ($urandom_range(0, 7))
         0: return -32768;
         1: return 32767;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Driver: presents one beat at a time from pending_actions, holds it
   // until start && !busy, and inserts random idle bursts between beats.
   // CSR writes and settle points wait until the block has drained.
   // start and csr_write_enable get exactly one nonblocking assignment per edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      stim_item head;
      logic     fire;
      logic     next_start;
      logic     next_we;
      logic     settled;
      int       next_gap;
      fire       = start && !busy;
      next_start = start && !fire;
      next_we    = 1'b0;
      next_gap   = idle_left;
      // block is idle: no result owed and nothing on either channel for a while
      settled    = (quiet_cycles >= SETTLE_CYCLES) && (expected_limits.size() == 0);
      if (reset) begin
         next_start = 1'b0;
         next_gap   = 0;
      end else begin
         // a burst of idle cycles after roughly one beat in six
         if (fire && !beat_calm && $urandom_range(0, 5) == 0)
            next_gap = $urandom_range(1, 16);
         if (!next_start) begin
            if (next_gap != 0) begin
               next_gap--;
            end else if (pending_actions.size() != 0) begin
               if (pending_actions[0].kind == ACT_BEAT || settled) begin
                  head = pending_actions.pop_front();
                  if (head.kind == ACT_BEAT) begin
                     next_start      = 1'b1;
                     beat_calm       = head.calm;
                     req_type        <= head.op;
                     req_entry_index <= head.index;
                     req_point_pan   <= head.pan;
                     req_point_lower <= head.lower;
                     req_point_upper <= head.upper;
                     req_query_pan   <= head.qpan;
                  end else if (head.kind == ACT_CSR) begin
                     next_we        = 1'b1;
                     csr_write_data <= head.count;
                  end
               end
            end
         end
      end
      if (fire || rsp_strobe || reset)
         quiet_cycles <= 0;
      else if (quiet_cycles < SETTLE_CYCLES)
         quiet_cycles <= quiet_cycles + 1;
      start            <= next_start;
      csr_write_enable <= next_we;
      idle_left        <= next_gap;
   end

   // ------------------------------------------------------------------
   // Monitor: checks each result beat against the oldest expectation,
   // then folds in this edge's accepted beat and CSR write. Inputs are
   // sampled at the edge, before the driver's updates land.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      tilt_result got;
      tilt_result want;
      if (!reset) begin
         if (rsp_strobe) begin
            got = '{rsp_reachable, rsp_tilt_upper, rsp_tilt_lower};
            if (expected_limits.size() == 0) begin
               $error("result beat with no query outstanding");
               error_count++;
            end else begin
               want = expected_limits.pop_front();
               if (got.reachable !== want.reachable) begin
                  $error("reachable: expected %0d, got %0d",
                         want.reachable, got.reachable);
                  error_count++;
               end
               if (got.upper !== want.upper) begin
                  $error("tilt_upper: expected %0d, got %0d",
                         $signed(want.upper), $signed(got.upper));
                  error_count++;
               end
               if (got.lower !== want.lower) begin
                  $error("tilt_lower: expected %0d, got %0d",
                         $signed(want.lower), $signed(got.lower));
                  error_count++;
               end
            end
         end
         if (csr_write_enable)
            active_points = csr_write_data;
         if (start && !busy) begin
            if (req_type == OP_QUERY) begin
               expected_limits.push_back(predict_tilt(req_query_pan));
            end else begin
               tbl_pan[req_entry_index]   = req_point_pan;
               tbl_lower[req_entry_index] = req_point_lower;
               tbl_upper[req_entry_index] = req_point_upper;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and verdict.
   // ------------------------------------------------------------------
   initial begin
      int gen_pan [MAX_POINTS];
      int phase;
      int n_pts;
      int lo_b;
      int hi_b;
      int span;
      int n_query;
      int k;
      int gap;
      int qp;
      int tmp;

      // Directed: empty table, so nothing is read
      push_control(ACT_CSR, 0);
      push_query(0);
      push_query(-32768);
      // evenly spread table over the whole pan range, limits swinging rail
      // to rail so each segment interpolates across the full span
      for (int i = 0; i < MAX_POINTS; i++)
         push_load(i, -32768 + i * 4369, (i % 2) ? 32767 : -32768,
                   (i % 2) ? -32768 : 32767);
      push_control(ACT_CSR, 16);
      push_query(-32768);          // exact hit, first entry
      push_query(32767);           // exact hit, last entry
      push_query(-32767);          // one step past a breakpoint
      push_query(-28400);          // one step short of the next breakpoint
      push_query(0);               // middle of a segment
      push_control(ACT_CSR, 4);
      push_query(32767);           // beyond the searched entries
      push_query(-19661);          // exact hit on the last searched entry
      push_control(ACT_CSR, 31);   // saturates to the full table
      push_query(1);
      // first entry moved above its neighbor: unsorted table
      push_load(0, 0, 100, -100);
      push_control(ACT_CSR, 16);
      push_query(-5);              // below the first entry
      push_query(1000);            // scan passes entries out of order
      push_control(ACT_SETTLE, 0);

      // Random phases: new count, fresh sorted table, then aimed queries
      random_beats = 0;
      phase        = 0;
      while (random_beats < RANDOM_BEATS) begin
         case (phase)
            0: n_pts = 16;
            1: n_pts = 0;
            2: n_pts = 31;
            3: n_pts = 1;
            4: n_pts = 2;
            5: n_pts = 17;
            default: n_pts = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                         : $urandom_range(2, 16);
         endcase
         push_control(ACT_CSR, n_pts);

         // pan spread: full range, a few thousand, or a tight cluster
         case ($urandom_range(0, 2))
            0: span = 65535;
            1: span = $urandom_range(16, 4096);
            default: span = $urandom_range(0, 48);
         endcase
         lo_b = int'($urandom_range(0, 65535)) - 32768;
         hi_b = (lo_b + span > 32767) ? 32767 : lo_b + span;
         for (int i = 0; i < MAX_POINTS; i++)
            gen_pan[i] = lo_b + int'($urandom_range(0, hi_b - lo_b));
         for (int i = 1; i < MAX_POINTS; i++)
            for (int j = i; j > 0 && gen_pan[j-1] > gen_pan[j]; j--) begin
               tmp          = gen_pan[j];
               gen_pan[j]   = gen_pan[j-1];
               gen_pan[j-1] = tmp;
            end
         for (int i = 0; i < MAX_POINTS; i++)
            push_load(i, gen_pan[i], pick_limit(), pick_limit());

         n_query = $urandom_range(20, 60);
         for (int q = 0; q < n_query; q++) begin
            // stray single-entry rewrite; may leave the table unsorted
            if ($urandom_range(0, 9) == 0) begin
               k          = $urandom_range(0, MAX_POINTS - 1);
               gen_pan[k] = int'($urandom_range(0, 65535)) - 32768;
               push_load(k, gen_pan[k], pick_limit(), pick_limit());
            end
            if ($urandom_range(0, 39) == 0)
               push_control(ACT_SETTLE, 0);
            k   = $urandom_range(1, MAX_POINTS - 1);
            gap = gen_pan[k] - gen_pan[k-1];
            qp  = int'($urandom_range(0, 65535)) - 32768;
            case ($urandom_range(0, 5))
               0: qp = gen_pan[$urandom_range(0, MAX_POINTS - 1)];
               1, 2: if (gap > 1)
                  qp = gen_pan[k-1] + 1 + int'($urandom_range(0, gap - 2));
               3: if (gap > 1)
                  qp = $urandom_range(0, 1) ? gen_pan[k-1] + 1 : gen_pan[k] - 1;
               4: if (gen_pan[0] > -32768)
                  qp = -32768 + int'($urandom_range(0, gen_pan[0] + 32767));
               default: if (gen_pan[MAX_POINTS-1] < 32767)
                  qp = gen_pan[MAX_POINTS-1] + 1 +
                       int'($urandom_range(0, 32766 - gen_pan[MAX_POINTS-1]));
            endcase
            push_query(qp);
         end
         phase++;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // all stimulus taken and every result back, then a quiet tail
      do @(negedge clock);
      while (pending_actions.size() != 0 || start || expected_limits.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0 && expected_limits.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #10ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
